FILE: hw/rtl/matrix4_vector_transform_assert.svh
// assertion macros used by the transform rtl
`ifndef MATRIX4_VECTOR_TRANSFORM_ASSERT_SVH
`define MATRIX4_VECTOR_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define M4VT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m4vt assertion failed");

// next-cycle implication
`define M4VT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m4vt assertion failed");

`endif

FILE: hw/rtl/m4vt_pkg.sv
package m4vt_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FIELD_W    = 32;
    localparam int CFG_W      = 64;
    localparam int SLOT_W     = CFG_W / 2;
    localparam int N_CFG      = 8;
    localparam int CFG_SEL_W  = $clog2(N_CFG);
    localparam int CFG_IDX_W  = 4;
    localparam int N_DIM      = 4;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;

    localparam logic [CFG_W-1:0] COEF_ONE = CFG_W'(1) << FRAC_BITS;

    // identity matrix, register 7 first
    localparam logic [N_CFG-1:0][CFG_W-1:0] CFG_RESET = {
        COEF_ONE << SLOT_W, CFG_W'(0),
        COEF_ONE,           CFG_W'(0),
        CFG_W'(0),          COEF_ONE << SLOT_W,
        CFG_W'(0),          COEF_ONE
    };

    typedef struct packed {
        logic signed [FIELD_W-1:0] in_x;
        logic signed [FIELD_W-1:0] in_y;
        logic signed [FIELD_W-1:0] in_z;
        logic signed [FIELD_W-1:0] in_w;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
        logic signed [FIELD_W-1:0] out_w;
        logic                      saturated;
    } t_out_item;

    typedef logic [N_DIM-1:0][DATA_WIDTH-1:0]             t_vec;
    typedef logic [N_DIM-1:0][N_DIM-1:0][DATA_WIDTH-1:0]  t_coef_mat;
    typedef logic [N_DIM-1:0][N_DIM-1:0][PROD_W-1:0]      t_prod_mat;
    typedef logic [N_DIM-1:0][1:0][PAIR_W-1:0]            t_pair_mat;

endpackage

FILE: hw/rtl/m4vt_cfg.sv
module m4vt_cfg
    import m4vt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_coef_mat            o_coef
);

    logic [N_CFG-1:0][CFG_W-1:0] r_regs;

    assign o_cfg_ready = 1'b1;

    // writes past the last register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= CFG_RESET;
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(N_CFG))) begin
            r_regs[i_cfg_index[CFG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    for (genvar r = 0; r < N_DIM; r++) begin : g_row
        for (genvar c = 0; c < N_DIM; c++) begin : g_col
            assign o_coef[r][c] = r_regs[r * 2 + c / 2][(c % 2) * SLOT_W +: DATA_WIDTH];
        end
    end

endmodule

FILE: hw/rtl/m4vt_mul.sv
module m4vt_mul
    import m4vt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_vec      i_vec,
    input  t_coef_mat i_coef,
    output logic      o_valid,
    input  logic      i_ready,
    output t_prod_mat o_prod
);

    logic                     r_valid;
    t_prod_mat                r_prod;
    t_prod_mat                n_prod;
    logic signed [DATA_WIDTH-1:0] w_a [N_DIM][N_DIM];
    logic signed [DATA_WIDTH-1:0] w_b [N_DIM];
    logic signed [PROD_W-1:0]     w_p [N_DIM][N_DIM];

    for (genvar c = 0; c < N_DIM; c++) begin : g_vec
        assign w_b[c] = i_vec[c];
    end

    // sixteen full products, one per coefficient
    for (genvar r = 0; r < N_DIM; r++) begin : g_row
        for (genvar c = 0; c < N_DIM; c++) begin : g_col
            assign w_a[r][c]    = i_coef[r][c];
            assign w_p[r][c]    = w_a[r][c] * w_b[c];
            assign n_prod[r][c] = w_p[r][c];
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_prod  = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

endmodule

FILE: hw/rtl/m4vt_add.sv
module m4vt_add
    import m4vt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_prod_mat i_prod,
    output logic      o_valid,
    input  logic      i_ready,
    output t_pair_mat o_pair
);

    logic      r_valid;
    t_pair_mat r_pair;
    t_pair_mat n_pair;

    // columns 0+1 and 2+3 of each row, sign extended by one bit
    for (genvar r = 0; r < N_DIM; r++) begin : g_row
        for (genvar h = 0; h < 2; h++) begin : g_half
            assign n_pair[r][h] = {i_prod[r][2*h][PROD_W-1], i_prod[r][2*h]}
                                + {i_prod[r][2*h+1][PROD_W-1], i_prod[r][2*h+1]};
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_pair  = r_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pair <= n_pair;
        end
    end

endmodule

FILE: hw/rtl/m4vt_sat.sv
module m4vt_sat
    import m4vt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_pair_mat i_pair,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam logic [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam int HI_LSB = FRAC_BITS + DATA_WIDTH - 1;

    logic                  r_valid;
    t_out_item             r_item;
    t_out_item             n_item;
    logic [SUM_W-1:0]      w_sum [N_DIM];
    logic [SUM_W-1-HI_LSB:0] w_hi [N_DIM];
    logic [N_DIM-1:0]      w_ovf;
    logic signed [DATA_WIDTH-1:0] w_res [N_DIM];
    logic [N_DIM-1:0][FIELD_W-1:0] w_field;

    for (genvar r = 0; r < N_DIM; r++) begin : g_row
        assign w_sum[r] = {i_pair[r][0][PAIR_W-1], i_pair[r][0]}
                        + {i_pair[r][1][PAIR_W-1], i_pair[r][1]};
        // bits above the kept window must all match the sign
        assign w_hi[r]  = w_sum[r][SUM_W-1:HI_LSB];
        assign w_ovf[r] = !((&w_hi[r]) || !(|w_hi[r]));
        assign w_res[r] = !w_ovf[r] ? w_sum[r][HI_LSB:FRAC_BITS] :
                          (w_sum[r][SUM_W-1] ? MIN_V : MAX_V);
        assign w_field[r] = FIELD_W'(w_res[r]);
    end

    always_comb begin
        n_item.out_x     = w_field[0];
        n_item.out_y     = w_field[1];
        n_item.out_z     = w_field[2];
        n_item.out_w     = w_field[3];
        n_item.saturated = |w_ovf;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: hw/rtl/matrix4_vector_transform.sv
// 4x4 matrix times vector, signed fixed point (Q16.16 by default).
// input channel: i_in_valid / o_in_stall with i_in_data (x, y, z, w);
// a transfer happens on a rising edge with valid high and stall low.
// output channel: o_out_valid / i_out_stall with o_out_data, four saturated
// components and a flag set when any component was clamped.
// config channel: i_cfg_valid / o_cfg_ready, i_cfg_index picks one of eight
// 64-bit registers, two coefficients each, row by row, low half first.
// o_cfg_ready is always high; an index of eight or more is ignored.
// from input transfer to output valid the pipeline is a multiply stage
// (sixteen 32x32 products), a pair-add stage, and a final add with
// shift and saturation that is also the output register.
// throughput is one vector per cycle; every stage holds its item while the
// next one is full, so a stall on the output fills the pipeline and then
// raises o_in_stall without losing or repeating anything.
// reset (synchronous, active low) empties the pipeline and loads the
// identity matrix into the configuration registers.
`include "matrix4_vector_transform_assert.svh"

module matrix4_vector_transform
    import m4vt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_coef_mat w_coef;
    t_vec      w_vec;
    logic      w_mul_ready;
    logic      w_mul_valid;
    t_prod_mat w_prod;
    logic      w_add_ready;
    logic      w_add_valid;
    t_pair_mat w_pair;
    logic      w_sat_ready;

    assign w_vec[0] = i_in_data.in_x[DATA_WIDTH-1:0];
    assign w_vec[1] = i_in_data.in_y[DATA_WIDTH-1:0];
    assign w_vec[2] = i_in_data.in_z[DATA_WIDTH-1:0];
    assign w_vec[3] = i_in_data.in_w[DATA_WIDTH-1:0];

    m4vt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (w_coef)
    );

    m4vt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (w_mul_ready),
        .i_vec   (w_vec),
        .i_coef  (w_coef),
        .o_valid (w_mul_valid),
        .i_ready (w_add_ready),
        .o_prod  (w_prod)
    );

    m4vt_add u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_valid),
        .o_ready (w_add_ready),
        .i_prod  (w_prod),
        .o_valid (w_add_valid),
        .i_ready (w_sat_ready),
        .o_pair  (w_pair)
    );

    m4vt_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_add_valid),
        .o_ready (w_sat_ready),
        .i_pair  (w_pair),
        .o_valid (o_out_valid),
        .i_ready (!i_out_stall),
        .o_item  (o_out_data)
    );

    assign o_in_stall = !w_mul_ready;

    // input only stalls with every stage full
    `M4VT_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_in_stall,
        w_mul_valid && w_add_valid && o_out_valid)

    // a free output never backs up to the input
    `M4VT_ASSERT_IMP(a_no_false_stall, i_clk, i_rst_n, !i_out_stall, !o_in_stall)

    // clamped result shows a rail value somewhere
    `M4VT_ASSERT_IMP(a_sat_rail, i_clk, i_rst_n, o_out_valid && o_out_data.saturated,
        (o_out_data.out_x == FIELD_W'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}))) ||
        (o_out_data.out_x == FIELD_W'($signed({1'b1, {(DATA_WIDTH-1){1'b0}}}))) ||
        (o_out_data.out_y == FIELD_W'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}))) ||
        (o_out_data.out_y == FIELD_W'($signed({1'b1, {(DATA_WIDTH-1){1'b0}}}))) ||
        (o_out_data.out_z == FIELD_W'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}))) ||
        (o_out_data.out_z == FIELD_W'($signed({1'b1, {(DATA_WIDTH-1){1'b0}}}))) ||
        (o_out_data.out_w == FIELD_W'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}))) ||
        (o_out_data.out_w == FIELD_W'($signed({1'b1, {(DATA_WIDTH-1){1'b0}}}))))

    // an unstalled transfer reaches the output through the multiply, pair-add and saturation registers
    `M4VT_ASSERT_NXT(a_latency, i_clk, i_rst_n,
        (i_in_valid && !o_in_stall) ##1 !i_out_stall ##1 !i_out_stall, o_out_valid)

endmodule

FILE: dv/matrix4_vector_transform_tb.sv
`timescale 1ns / 1ps

module matrix4_vector_transform_tb;
    import m4vt_pkg::*;

    typedef logic [3:0][3:0][31:0] t_coef_grid;

    // registers follow row by row, low half before high half
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_LO = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LAST    = CFG_IDX_W'((1 << CFG_IDX_W) - 1);

    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_HALF = 32'h0000_8000;
    localparam logic [31:0] Q_LSB  = 32'h0000_0001;
    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;

    localparam int Q_FRAC = 16;
    localparam logic signed [67:0] COMP_MAX = (68'sd1 <<< 31) - 68'sd1;
    localparam logic signed [67:0] COMP_MIN = -(68'sd1 <<< 31);

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_VERTICES = 250;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out_item out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    logic [CFG_W-1:0] coef_regs [N_CFG];
    t_out_item predicted_vertices [$];
    t_out_item want;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int rx_wait = 0;
    int rx_hold_cycles = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int vertices_sent = 0;
    int results_checked = 0;
    int saturated_results = 0;
    int matrices_loaded = 0;

    matrix4_vector_transform dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_out_item transform_vertex(input t_in_item v);
        logic signed [31:0] comp [4];
        logic signed [67:0] acc;
        logic signed [67:0] a;
        logic signed [67:0] b;
        logic [CFG_W-1:0] regv;
        logic [31:0] half;
        logic [31:0] row_out [4];
        t_out_item res;
        res = '0;
        comp[0] = v.in_x;
        comp[1] = v.in_y;
        comp[2] = v.in_z;
        comp[3] = v.in_w;
        for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int c = 0; c < 4; c++) begin
                regv = coef_regs[2 * r + c / 2];
                half = (c % 2 == 1) ? regv[63:32] : regv[31:0];
                a = 68'($signed(half));
                b = 68'(comp[c]);
                acc = acc + a * b;
            end
            // exact sum, then floor toward minus infinity
            acc = acc >>> Q_FRAC;
            if (acc > COMP_MAX) begin
                acc = COMP_MAX;
                res.saturated = 1'b1;
            end else if (acc < COMP_MIN) begin
                acc = COMP_MIN;
                res.saturated = 1'b1;
            end
            row_out[r] = acc[31:0];
        end
        res.out_x = row_out[0];
        res.out_y = row_out[1];
        res.out_z = row_out[2];
        res.out_w = row_out[3];
        return res;
    endfunction

    function automatic logic [31:0] draw_fixed(input int min_shift);
        logic [31:0] raw;
        logic [31:0] val;
        raw = $urandom;
        case ($urandom_range(0, 7))
            0: begin
                case (raw[2:0])
                    3'd0: val = Q_MAX;
                    3'd1: val = Q_MIN;
                    3'd2: val = '0;
                    3'd3: val = 32'hFFFF_FFFF;
                    3'd4: val = Q_ONE;
                    3'd5: val = -Q_ONE;
                    3'd6: val = Q_LSB;
                    default: val = Q_HALF;
                endcase
            end
            1: val = raw;
            default: val = $signed(raw) >>> $urandom_range(min_shift, 31);
        endcase
        return val;
    endfunction

    function automatic t_in_item vec4(input logic [31:0] x, y, z, w);
        t_in_item v;
        v.in_x = x;
        v.in_y = y;
        v.in_z = z;
        v.in_w = w;
        return v;
    endfunction

    function automatic t_in_item random_vertex(input int min_shift);
        return vec4(draw_fixed(min_shift), draw_fixed(min_shift),
                    draw_fixed(min_shift), draw_fixed(min_shift));
    endfunction

    task automatic send_vertex(input t_in_item v);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= v;
        do @(posedge clk); while (in_stall);
        predicted_vertices.push_back(transform_vertex(v));
        vertices_sent++;
    endtask

    task automatic drain_pipeline;
        in_valid <= 1'b0;
        do @(posedge clk); while (predicted_vertices.size() != 0);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        int gap;
        gap = $urandom_range(0, 2);
        if (gap > 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx < N_CFG)
            coef_regs[idx[CFG_SEL_W-1:0]] = value;
    endtask

    task automatic load_matrix(input t_coef_grid grid, input bit with_stray);
        logic [CFG_IDX_W-1:0] stray_at;
        stray_at = CFG_IDX_W'($urandom_range(0, N_CFG - 1));
        drain_pipeline();
        for (int r = 0; r < 4; r++) begin
            for (int h = 0; h < 2; h++) begin
                if (with_stray && stray_at == REG_ROW0_LO + 2 * r + h)
                    write_cfg(CFG_IDX_W'($urandom_range(N_CFG, REG_LAST)),
                              {$urandom, $urandom});
                write_cfg(REG_ROW0_LO + CFG_IDX_W'(2 * r + h),
                          {grid[r][2 * h + 1], grid[r][2 * h]});
            end
        end
        cfg_valid <= 1'b0;
        matrices_loaded++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    // result checking and receiver stall
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (predicted_vertices.size() == 0) begin
                $error("output transfer with no vertex pending");
                mismatch_count++;
            end else begin
                want = predicted_vertices.pop_front();
                check_field("out_x", want.out_x, out_data.out_x);
                check_field("out_y", want.out_y, out_data.out_y);
                check_field("out_z", want.out_z, out_data.out_z);
                check_field("out_w", want.out_w, out_data.out_w);
                check_field("saturated", 32'(want.saturated), 32'(out_data.saturated));
                results_checked++;
                if (out_data.saturated)
                    saturated_results++;
            end
            rx_wait = rx_idle_en ? $urandom_range(0, 13) : 0;
        end
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
        $error("no transfer for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic test_reset_identity;
        send_vertex(vec4(Q_MAX, Q_MIN, '0, Q_LSB));
        send_vertex(vec4(Q_MIN, Q_MAX, 32'hFFFF_FFFF, Q_ONE));
        send_vertex(vec4(32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 32'h8765_4321));
    endtask

    task automatic test_saturation;
        t_coef_grid grid;
        grid = {16{Q_MAX}};
        load_matrix(grid, 1'b0);
        send_vertex(vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_vertex(vec4(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        grid = {16{Q_MIN}};
        load_matrix(grid, 1'b0);
        send_vertex(vec4(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_vertex(vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        // one row clamps high, one low, the others stay in range
        grid = '0;
        grid[0] = {4{Q_MAX}};
        grid[1] = {4{Q_MIN}};
        grid[3][0] = Q_ONE;
        load_matrix(grid, 1'b0);
        send_vertex(vec4(Q_MAX, Q_MAX, Q_MIN, Q_ONE));
    endtask

    task automatic test_truncation;
        t_coef_grid grid;
        grid = '0;
        grid[0] = {4{Q_LSB}};
        grid[1] = {4{Q_HALF}};
        grid[2] = {4{-Q_HALF}};
        grid[3][0] = Q_ONE;
        grid[3][1] = -Q_ONE;
        grid[3][2] = Q_LSB;
        grid[3][3] = -Q_LSB;
        load_matrix(grid, 1'b0);
        send_vertex(vec4(32'hFFFF_FFFF, Q_LSB, 32'hFFFF_0000, 32'h0000_FFFF));
        send_vertex(vec4(Q_LSB, Q_LSB, Q_LSB, Q_LSB));
        send_vertex(vec4(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_vertex(vec4(32'd3, 32'hFFFF_FFFD, 32'd7, 32'hFFFF_FFF9));
    endtask

    task automatic test_range_boundary;
        t_coef_grid grid;
        grid = '0;
        grid[0][0] = Q_ONE;
        grid[0][1] = Q_ONE;
        grid[1][2] = Q_ONE;
        grid[1][3] = Q_ONE;
        grid[2][0] = Q_ONE;
        grid[2][2] = Q_ONE;
        grid[3][1] = Q_ONE;
        grid[3][3] = Q_ONE;
        load_matrix(grid, 1'b0);
        // one lsb past either end clamps, the ends themselves do not
        send_vertex(vec4(Q_MAX, Q_LSB, Q_MIN, 32'hFFFF_FFFF));
        send_vertex(vec4(Q_MAX, '0, Q_MIN, '0));
    endtask

    task automatic test_stray_cfg_index;
        drain_pipeline();
        for (int i = N_CFG; i <= REG_LAST; i++)
            write_cfg(CFG_IDX_W'(i), {$urandom, $urandom});
        cfg_valid <= 1'b0;
        send_vertex(random_vertex(4));
        send_vertex(vec4(Q_MAX, Q_ONE, Q_MIN, Q_ONE));
    endtask

    task automatic test_random_phases;
        t_coef_grid grid;
        int kind;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            kind = p % 3;
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    grid[r][c] = (kind == 2) ? $urandom : draw_fixed(kind == 0 ? 14 : 4);
            load_matrix(grid, p % 2 == 1);
            tx_idle_en = (p != 3 && p != 5);
            rx_idle_en = (p != 3);
            for (int i = 0; i < PHASE_VERTICES; i++)
                send_vertex(kind == 2 && i % 2 == 0 ? vec4($urandom, $urandom, $urandom, $urandom)
                                                    : random_vertex(4));
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_output_backpressure;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < 40; i++) begin
            // long receiver hold-off while the sender keeps offering
            if (i == 8)
                rx_hold_cycles = 120;
            send_vertex(random_vertex(4));
        end
        // sender waits for every pending result before going on
        drain_pipeline();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int i = 0; i < 40; i++)
            send_vertex(random_vertex(4));
    endtask

    initial begin
        coef_regs[0] = CFG_W'(Q_ONE);
        coef_regs[1] = '0;
        coef_regs[2] = {Q_ONE, 32'h0};
        coef_regs[3] = '0;
        coef_regs[4] = '0;
        coef_regs[5] = CFG_W'(Q_ONE);
        coef_regs[6] = '0;
        coef_regs[7] = {Q_ONE, 32'h0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_identity();
        test_saturation();
        test_truncation();
        test_range_boundary();
        test_stray_cfg_index();
        test_random_phases();
        test_output_backpressure();

        drain_pipeline();
        repeat (8) @(posedge clk);

        $display("%0d vertices sent, %0d results checked, %0d of them clamped",
                 vertices_sent, results_checked, saturated_results);
        $display("%0d matrix loads: extremes, floor rounding, range ends, random; "
                 , matrices_loaded, "ignored high register indexes and output hold-off");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
